// ----- rtl/crp_pkg.sv -----
// Shared types and constants of the canonical record parser.
// Used by crp_front, crp_queue, canonical_record_parser and the testbench; depends on nothing.
package crp_pkg;

    // Parser phases, in record order.
    typedef enum logic [3:0] {
        PH_VER,
        PH_KIND,
        PH_NSL,
        PH_NSD,
        PH_ENL,
        PH_END,
        PH_PRS,
        PH_FLL,
        PH_FLD,
        PH_VLL,
        PH_VLD,
        PH_PHY,
        PH_LOG,
        PH_AUT,
        PH_SIG,
        PH_FIN
    } phase_t;

    // Status reported on the item that ends a record.
    typedef enum logic [2:0] {
        ST_OK,
        ST_BAD_VERSION,
        ST_BAD_KIND,
        ST_BAD_VARINT,
        ST_TRUNCATED
    } status_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_EXPECTED_VERSION,
        CFG_EXISTENCE_KIND,
        CFG_REGISTER_KIND,
        CFG_AUTHOR_KEY_LEN,
        CFG_SIGNATURE_LEN
    } cfg_index_t;

    // Field tags.
    localparam logic [3:0] TAG_NAMESPACE = 4'd0;
    localparam logic [3:0] TAG_ENTITY    = 4'd1;
    localparam logic [3:0] TAG_FIELD     = 4'd2;
    localparam logic [3:0] TAG_VALUE     = 4'd3;
    localparam logic [3:0] TAG_PRESENT   = 4'd4;
    localparam logic [3:0] TAG_PHYSICAL  = 4'd5;
    localparam logic [3:0] TAG_LOGICAL   = 4'd6;
    localparam logic [3:0] TAG_AUTHOR    = 4'd7;
    localparam logic [3:0] TAG_SIGNATURE = 4'd8;

    // Configuration reset values.
    localparam logic [7:0] RST_EXPECTED_VERSION = 8'd1;
    localparam logic [7:0] RST_EXISTENCE_KIND   = 8'd0;
    localparam logic [7:0] RST_REGISTER_KIND    = 8'd1;
    localparam logic [7:0] RST_AUTHOR_KEY_LEN   = 8'd32;
    localparam logic [7:0] RST_SIGNATURE_LEN    = 8'd64;

    // LEB128 group handling.
    localparam logic [7:0] VARINT_DATA_MASK = 8'h7f;
    localparam logic [7:0] VARINT_CONT_MASK = 8'h80;
    localparam logic [7:0] VARINT_TOP_MASK  = 8'h7e;
    localparam logic [3:0] VARINT_LAST_GROUP = 4'd9;

    // Fixed field lengths.
    localparam logic [63:0] LEN_PRESENT  = 64'd1;
    localparam logic [63:0] LEN_PHYSICAL = 64'd8;
    localparam logic [63:0] LEN_LOGICAL  = 64'd4;

    // Result queue between the front and the output side.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Configuration register set.
    typedef struct packed {
        logic [7:0] expected_version;
        logic [7:0] existence_kind_code;
        logic [7:0] register_kind_code;
        logic [7:0] author_key_length;
        logic [7:0] signature_length;
    } cfg_t;

    // One result item.
    typedef struct packed {
        logic [3:0]  field_tag;
        logic        data_valid;
        logic [7:0]  payload_byte;
        logic        field_end;
        logic        record_kind;
        logic        record_done;
        status_t     status;
        logic [31:0] consumed_bytes;
    } result_t;

endpackage

// ----- rtl/crp_front.sv -----
// Front of the canonical record parser: takes one byte per cycle while the queue
// has room, runs the record state machine and pushes result items. Depends on crp_pkg.
module crp_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  crp_pkg::cfg_t    cfg,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_in_byte,
    input  logic             s_buffer_end,
    input  logic             queue_room,
    output logic             push,
    output crp_pkg::result_t push_data
);

    crp_pkg::phase_t phase_reg, phase_next;
    logic            kind_reg, kind_next;
    logic [63:0]     varint_value_reg, varint_value_next;
    logic [3:0]      varint_group_reg, varint_group_next;
    logic [63:0]     bytes_remaining_reg, bytes_remaining_next;
    logic [31:0]     byte_count_reg, byte_count_next;
    logic            drain_reg, drain_next;

    logic            accept;
    crp_pkg::status_t err;
    logic            fin;
    logic            data;
    logic            fend;
    logic [3:0]      tag;
    logic [7:0]      pay;

    function automatic logic is_len(input crp_pkg::phase_t ph);
        return (ph == crp_pkg::PH_NSL) || (ph == crp_pkg::PH_ENL) ||
               (ph == crp_pkg::PH_FLL) || (ph == crp_pkg::PH_VLL);
    endfunction

    function automatic crp_pkg::phase_t next_phase(input crp_pkg::phase_t ph,
                                                   input logic kind);
        crp_pkg::phase_t nx;
        unique case (ph)
            crp_pkg::PH_NSD: nx = crp_pkg::PH_ENL;
            crp_pkg::PH_END: nx = kind ? crp_pkg::PH_FLL : crp_pkg::PH_PRS;
            crp_pkg::PH_PRS: nx = crp_pkg::PH_PHY;
            crp_pkg::PH_FLD: nx = crp_pkg::PH_VLL;
            crp_pkg::PH_VLD: nx = crp_pkg::PH_PHY;
            crp_pkg::PH_PHY: nx = crp_pkg::PH_LOG;
            crp_pkg::PH_LOG: nx = crp_pkg::PH_AUT;
            crp_pkg::PH_AUT: nx = crp_pkg::PH_SIG;
            default:         nx = crp_pkg::PH_FIN;
        endcase
        return nx;
    endfunction

    function automatic logic [63:0] fixed_len(input crp_pkg::phase_t ph,
                                              input crp_pkg::cfg_t c);
        logic [63:0] len;
        unique case (ph)
            crp_pkg::PH_PRS: len = crp_pkg::LEN_PRESENT;
            crp_pkg::PH_PHY: len = crp_pkg::LEN_PHYSICAL;
            crp_pkg::PH_LOG: len = crp_pkg::LEN_LOGICAL;
            crp_pkg::PH_AUT: len = {56'd0, c.author_key_length};
            crp_pkg::PH_SIG: len = {56'd0, c.signature_length};
            default:         len = 64'd0;
        endcase
        return len;
    endfunction

    function automatic logic [3:0] tag_of(input crp_pkg::phase_t ph);
        logic [3:0] t;
        unique case (ph)
            crp_pkg::PH_NSD: t = crp_pkg::TAG_NAMESPACE;
            crp_pkg::PH_END: t = crp_pkg::TAG_ENTITY;
            crp_pkg::PH_FLD: t = crp_pkg::TAG_FIELD;
            crp_pkg::PH_VLD: t = crp_pkg::TAG_VALUE;
            crp_pkg::PH_PRS: t = crp_pkg::TAG_PRESENT;
            crp_pkg::PH_PHY: t = crp_pkg::TAG_PHYSICAL;
            crp_pkg::PH_LOG: t = crp_pkg::TAG_LOGICAL;
            crp_pkg::PH_AUT: t = crp_pkg::TAG_AUTHOR;
            default:         t = crp_pkg::TAG_SIGNATURE;
        endcase
        return t;
    endfunction

    // The front stalls only when the queue has no free entry.
    assign s_ready = queue_room;
    assign accept  = s_valid && queue_room;

    // Next state: classify the byte, decode lengths and step through the fields.
    always_comb begin
        logic            req;
        crp_pkg::phase_t req_phase;
        logic [63:0]     req_len;
        logic            resolved;
        logic [63:0]     value_ins;
        logic [6:0]      shift_amt;

        phase_next           = phase_reg;
        kind_next            = kind_reg;
        varint_value_next    = varint_value_reg;
        varint_group_next    = varint_group_reg;
        bytes_remaining_next = bytes_remaining_reg;
        byte_count_next      = byte_count_reg;
        drain_next           = drain_reg;
        err                  = crp_pkg::ST_OK;
        fin                  = 1'b0;
        data                 = 1'b0;
        fend                 = 1'b0;
        tag                  = crp_pkg::TAG_NAMESPACE;
        pay                  = 8'd0;
        req                  = 1'b0;
        req_phase            = crp_pkg::PH_FIN;
        req_len              = 64'd0;
        resolved             = 1'b0;
        shift_amt            = {varint_group_reg, 3'b000} - {3'b000, varint_group_reg};
        value_ins            = varint_value_reg |
                               ({57'd0, s_in_byte[6:0]} << shift_amt);

        if (accept && drain_reg) begin
            // Dropping bytes after an error until the buffer-end mark.
            if (s_buffer_end) begin
                drain_next = 1'b0;
                phase_next = crp_pkg::PH_VER;
            end
        end else if (accept) begin
            if (phase_reg == crp_pkg::PH_VER) begin
                kind_next       = 1'b0;
                byte_count_next = 32'd1;
                if (s_buffer_end) begin
                    err = crp_pkg::ST_TRUNCATED;
                end else if (s_in_byte != cfg.expected_version) begin
                    err = crp_pkg::ST_BAD_VERSION;
                end else begin
                    phase_next = crp_pkg::PH_KIND;
                end
            end else begin
                if (byte_count_reg != 32'hffff_ffff) begin
                    byte_count_next = byte_count_reg + 32'd1;
                end
                unique case (phase_reg)
                    crp_pkg::PH_KIND: begin
                        if (s_in_byte == cfg.existence_kind_code) begin
                            kind_next = 1'b0;
                        end else if (s_in_byte == cfg.register_kind_code) begin
                            kind_next = 1'b1;
                        end else begin
                            err = crp_pkg::ST_BAD_KIND;
                        end
                        if (err == crp_pkg::ST_OK) begin
                            req       = 1'b1;
                            req_phase = crp_pkg::PH_NSL;
                        end
                    end
                    crp_pkg::PH_NSL, crp_pkg::PH_ENL, crp_pkg::PH_FLL,
                    crp_pkg::PH_VLL: begin
                        if (varint_group_reg > crp_pkg::VARINT_LAST_GROUP) begin
                            err = crp_pkg::ST_BAD_VARINT;
                        end else if ((varint_group_reg == crp_pkg::VARINT_LAST_GROUP) &&
                                     ((s_in_byte & crp_pkg::VARINT_TOP_MASK) != 8'd0)) begin
                            err = crp_pkg::ST_BAD_VARINT;
                        end else begin
                            varint_value_next = value_ins;
                            if ((s_in_byte & crp_pkg::VARINT_CONT_MASK) == 8'd0) begin
                                if ((s_in_byte == 8'd0) && (varint_group_reg != 4'd0)) begin
                                    err = crp_pkg::ST_BAD_VARINT;
                                end else begin
                                    req       = 1'b1;
                                    req_phase = crp_pkg::phase_t'(phase_reg + 4'd1);
                                    req_len   = value_ins;
                                end
                            end else begin
                                varint_group_next = varint_group_reg + 4'd1;
                            end
                        end
                    end
                    crp_pkg::PH_NSD, crp_pkg::PH_END, crp_pkg::PH_PRS, crp_pkg::PH_FLD,
                    crp_pkg::PH_VLD, crp_pkg::PH_PHY, crp_pkg::PH_LOG, crp_pkg::PH_AUT,
                    crp_pkg::PH_SIG: begin
                        data = 1'b1;
                        tag  = tag_of(phase_reg);
                        pay  = (phase_reg == crp_pkg::PH_PRS) ?
                               {7'd0, (s_in_byte != 8'd0)} : s_in_byte;
                        if (bytes_remaining_reg <= 64'd1) begin
                            fend      = 1'b1;
                            req       = 1'b1;
                            req_phase = next_phase(phase_reg, kind_next);
                            req_len   = fixed_len(req_phase, cfg);
                        end else begin
                            bytes_remaining_next = bytes_remaining_reg - 64'd1;
                        end
                    end
                    default: begin
                        phase_next = crp_pkg::PH_VER;
                        err        = crp_pkg::ST_TRUNCATED;
                    end
                endcase
            end

            // Enter the requested phase, skipping fields of length zero.
            if (req) begin
                for (int i = 0; i < 3; i++) begin
                    if (!resolved) begin
                        if (req_phase == crp_pkg::PH_FIN) begin
                            fin      = 1'b1;
                            resolved = 1'b1;
                        end else if (is_len(req_phase) || (req_len != 64'd0)) begin
                            resolved = 1'b1;
                        end else begin
                            req_phase = next_phase(req_phase, kind_next);
                            req_len   = fixed_len(req_phase, cfg);
                        end
                    end
                end
                if (!fin) begin
                    phase_next = req_phase;
                    if (is_len(req_phase)) begin
                        varint_value_next = 64'd0;
                        varint_group_next = 4'd0;
                    end else begin
                        bytes_remaining_next = req_len;
                    end
                end
            end

            if ((err == crp_pkg::ST_OK) && !fin && s_buffer_end) begin
                err = crp_pkg::ST_TRUNCATED;
            end

            // A finished or failed record restarts at the version byte.
            if ((err != crp_pkg::ST_OK) || fin) begin
                phase_next = crp_pkg::PH_VER;
                drain_next = (err != crp_pkg::ST_OK) && !s_buffer_end;
            end
        end
    end

    // Outputs: build the result item for this byte.
    always_comb begin
        logic done;
        done                     = (err != crp_pkg::ST_OK) || fin;
        push                     = data || done;
        push_data.field_tag      = data ? tag : crp_pkg::TAG_NAMESPACE;
        push_data.data_valid     = data;
        push_data.payload_byte   = pay;
        push_data.field_end      = fend;
        push_data.record_kind    = kind_next;
        push_data.record_done    = done;
        push_data.status         = err;
        push_data.consumed_bytes = done ? byte_count_next : 32'd0;
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= crp_pkg::PH_VER;
            kind_reg            <= 1'b0;
            varint_value_reg    <= 64'd0;
            varint_group_reg    <= 4'd0;
            bytes_remaining_reg <= 64'd0;
            byte_count_reg      <= 32'd0;
            drain_reg           <= 1'b0;
        end else begin
            phase_reg           <= phase_next;
            kind_reg            <= kind_next;
            varint_value_reg    <= varint_value_next;
            varint_group_reg    <= varint_group_next;
            bytes_remaining_reg <= bytes_remaining_next;
            byte_count_reg      <= byte_count_next;
            drain_reg           <= drain_next;
        end
    end

    // No item is produced while bytes are being dropped.
    a_no_push_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !drain_reg)
        else $error("result produced while draining");

    // Every error status comes with record_done.
    a_err_is_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && (push_data.status != crp_pkg::ST_OK)) |-> push_data.record_done)
        else $error("error status without record_done");

    // A finished record leaves the parser waiting for a version byte or draining.
    a_done_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && push_data.record_done) |=> (phase_reg == crp_pkg::PH_VER))
        else $error("parser did not restart after record end");

    // An error before the buffer end starts the drain.
    a_err_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && (push_data.status != crp_pkg::ST_OK) && !s_buffer_end) |=> drain_reg)
        else $error("drain not started after error");

endmodule

// ----- rtl/crp_queue.sv -----
// Result queue of the canonical record parser: a short register FIFO that
// separates the parsing front from the output channel. Depends on crp_pkg.
module crp_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  crp_pkg::result_t push_data,
    output logic             room,
    output logic             m_valid,
    input  logic             m_ready,
    output crp_pkg::result_t m_data
);

    crp_pkg::result_t                entry_reg [crp_pkg::QUEUE_DEPTH];
    logic [crp_pkg::QUEUE_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [crp_pkg::QUEUE_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [crp_pkg::QUEUE_CW-1:0]    count_reg, count_next;
    logic                            do_push;
    logic                            do_pop;

    localparam logic [crp_pkg::QUEUE_AW-1:0] LAST_PTR =
        crp_pkg::QUEUE_AW'(crp_pkg::QUEUE_DEPTH - 1);
    localparam logic [crp_pkg::QUEUE_CW-1:0] FULL_COUNT =
        crp_pkg::QUEUE_CW'(crp_pkg::QUEUE_DEPTH);

    assign room    = (count_reg != FULL_COUNT);
    assign m_valid = (count_reg != '0);
    assign m_data  = entry_reg[rd_ptr_reg];
    assign do_push = push && room;
    assign do_pop  = m_valid && m_ready;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; payload needs no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // The fill count never exceeds the depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_COUNT)
        else $error("queue count above depth");

    // A lone push grows the count by one.
    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on push");

    // A lone pop shrinks the count by one.
    a_pop_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not shrink on pop");

endmodule

// ----- rtl/canonical_record_parser.sv -----
// Top level of the canonical record parser: configuration registers, the parsing
// front and the result queue. Depends on crp_pkg, crp_front and crp_queue.
//
//   Channel   Direction  Handshake            Payload
//   cfg       in         cfg_valid/cfg_ready  cfg_index (3), cfg_data (8)
//   s         in         s_valid/s_ready      s_in_byte (8), s_buffer_end (1)
//   m         out        m_valid/m_ready      m_field_tag .. m_consumed_bytes
//
// One record byte is accepted every cycle while the queue has room; at most one
// result item follows per byte and is offered on m from the registered result queue.
// s_ready falls only when the four-entry result queue is full, so stalls on m
// reach the input after four pending items. cfg_ready is always high.
// Reset is synchronous and active low; there is no clearing pass.
module canonical_record_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_buffer_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_field_tag,
    output logic        m_data_valid,
    output logic [7:0]  m_payload_byte,
    output logic        m_field_end,
    output logic        m_record_kind,
    output logic        m_record_done,
    output logic [2:0]  m_status,
    output logic [31:0] m_consumed_bytes
);

    crp_pkg::cfg_t    cfg_reg;
    logic             queue_room;
    logic             push;
    crp_pkg::result_t push_data;
    crp_pkg::result_t m_data;

    assign cfg_ready = 1'b1;

    // Configuration registers; writes beyond the register list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.expected_version    <= crp_pkg::RST_EXPECTED_VERSION;
            cfg_reg.existence_kind_code <= crp_pkg::RST_EXISTENCE_KIND;
            cfg_reg.register_kind_code  <= crp_pkg::RST_REGISTER_KIND;
            cfg_reg.author_key_length   <= crp_pkg::RST_AUTHOR_KEY_LEN;
            cfg_reg.signature_length    <= crp_pkg::RST_SIGNATURE_LEN;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                crp_pkg::CFG_EXPECTED_VERSION: cfg_reg.expected_version    <= cfg_data;
                crp_pkg::CFG_EXISTENCE_KIND:   cfg_reg.existence_kind_code <= cfg_data;
                crp_pkg::CFG_REGISTER_KIND:    cfg_reg.register_kind_code  <= cfg_data;
                crp_pkg::CFG_AUTHOR_KEY_LEN:   cfg_reg.author_key_length   <= cfg_data;
                crp_pkg::CFG_SIGNATURE_LEN:    cfg_reg.signature_length    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Parsing front.
    crp_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .s_buffer_end (s_buffer_end),
        .queue_room   (queue_room),
        .push         (push),
        .push_data    (push_data)
    );

    // Result queue driving the output channel.
    crp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .room      (queue_room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Output fields.
    assign m_field_tag      = m_data.field_tag;
    assign m_data_valid     = m_data.data_valid;
    assign m_payload_byte   = m_data.payload_byte;
    assign m_field_end      = m_data.field_end;
    assign m_record_kind    = m_data.record_kind;
    assign m_record_done    = m_data.record_done;
    assign m_status         = m_data.status;
    assign m_consumed_bytes = m_data.consumed_bytes;

endmodule

// ----- test/crp_stream_checker.sv -----
// Stream checker for the canonical record parser: predicts each result item from the
// accepted bytes and the register writes, and compares it with the m channel.
// Depends on crp_pkg for the phase, status, tag and register definitions.
`timescale 1ns / 100ps

module crp_stream_checker
    import crp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_buffer_end,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [3:0]  m_field_tag,
    input  logic        m_data_valid,
    input  logic [7:0]  m_payload_byte,
    input  logic        m_field_end,
    input  logic        m_record_kind,
    input  logic        m_record_done,
    input  logic [2:0]  m_status,
    input  logic [31:0] m_consumed_bytes,
    output int          mismatch_total,
    output int          results_pending
);

    // Local copy of the registers and of the decoder state.
    cfg_t        regs;
    phase_t      cur_phase;
    logic        kind_is_register;
    logic [63:0] length_acc;
    logic [6:0]  length_shift;
    logic [63:0] field_left;
    logic [31:0] record_count;
    logic        draining;

    result_t expected_results[$];
    int      mismatches = 0;
    int      pending_q = 0;

    assign mismatch_total  = mismatches;
    assign results_pending = pending_q;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t ns: %s got %0h expected %0h", $time, what, got, want);
        mismatches = mismatches + 1;
    endtask

    function automatic logic is_length_phase(input phase_t p);
        return p == PH_NSL || p == PH_ENL || p == PH_FLL || p == PH_VLL;
    endfunction

    // Record order; the branch after the entity depends on the record kind.
    function automatic phase_t after_phase(input phase_t p);
        case (p)
            PH_NSD:  return PH_ENL;
            PH_END:  return kind_is_register ? PH_FLL : PH_PRS;
            PH_PRS:  return PH_PHY;
            PH_FLD:  return PH_VLL;
            PH_VLD:  return PH_PHY;
            PH_PHY:  return PH_LOG;
            PH_LOG:  return PH_AUT;
            PH_AUT:  return PH_SIG;
            default: return PH_FIN;
        endcase
    endfunction

    function automatic logic [63:0] fixed_length(input phase_t p);
        case (p)
            PH_PRS:  return LEN_PRESENT;
            PH_PHY:  return LEN_PHYSICAL;
            PH_LOG:  return LEN_LOGICAL;
            PH_AUT:  return {56'd0, regs.author_key_length};
            PH_SIG:  return {56'd0, regs.signature_length};
            default: return 64'd0;
        endcase
    endfunction

    function automatic logic [3:0] tag_for(input phase_t p);
        case (p)
            PH_NSD:  return TAG_NAMESPACE;
            PH_END:  return TAG_ENTITY;
            PH_FLD:  return TAG_FIELD;
            PH_VLD:  return TAG_VALUE;
            PH_PRS:  return TAG_PRESENT;
            PH_PHY:  return TAG_PHYSICAL;
            PH_LOG:  return TAG_LOGICAL;
            PH_AUT:  return TAG_AUTHOR;
            default: return TAG_SIGNATURE;
        endcase
    endfunction

    // Move to a phase, skipping empty fields; returns 1 when the record is complete.
    function automatic logic enter_phase(input phase_t start, input logic [63:0] len);
        phase_t      p;
        logic [63:0] n;
        p = start;
        n = len;
        for (int i = 0; i < 16; i++) begin
            if (p == PH_FIN)
                return 1'b1;
            if (is_length_phase(p)) begin
                cur_phase    = p;
                length_acc   = 64'd0;
                length_shift = 7'd0;
                return 1'b0;
            end
            if (n != 64'd0) begin
                cur_phase  = p;
                field_left = n;
                return 1'b0;
            end
            p = after_phase(p);
            n = fixed_length(p);
        end
        return 1'b1;
    endfunction

    // Advance the decoder by one byte; returns 1 when the byte gives a result item.
    function automatic logic decode_record_byte(input logic [7:0] b, input logic last,
                                                output result_t r);
        logic       data;
        logic       fin;
        logic       fend;
        status_t    err;
        logic [3:0] tag;
        logic [7:0] pay;
        phase_t     nx;
        data = 1'b0;
        fin  = 1'b0;
        fend = 1'b0;
        err  = ST_OK;
        tag  = TAG_NAMESPACE;
        pay  = 8'd0;
        r    = '0;

        // Bytes after an error are dropped up to the buffer end.
        if (draining) begin
            if (last) begin
                draining  = 1'b0;
                cur_phase = PH_VER;
            end
            return 1'b0;
        end

        if (cur_phase == PH_VER) begin
            kind_is_register = 1'b0;
            record_count     = 32'd1;
            if (last)
                err = ST_TRUNCATED;
            else if (b != regs.expected_version)
                err = ST_BAD_VERSION;
            else
                cur_phase = PH_KIND;
        end else begin
            if (record_count != '1)
                record_count = record_count + 32'd1;
            if (cur_phase == PH_KIND) begin
                // Existence wins when both codes are equal.
                if (b == regs.existence_kind_code)
                    kind_is_register = 1'b0;
                else if (b == regs.register_kind_code)
                    kind_is_register = 1'b1;
                else
                    err = ST_BAD_KIND;
                if (err == ST_OK)
                    void'(enter_phase(PH_NSL, 64'd0));
            end else if (is_length_phase(cur_phase)) begin
                // Canonical LEB128: no overflow, no high bits in the tenth group, no padding.
                if (length_shift > 7'd63) begin
                    err = ST_BAD_VARINT;
                end else if (length_shift == 7'd63 && (b & VARINT_TOP_MASK) != 8'd0) begin
                    err = ST_BAD_VARINT;
                end else begin
                    length_acc = length_acc | ({56'd0, b & VARINT_DATA_MASK} << length_shift);
                    if ((b & VARINT_CONT_MASK) == 8'd0) begin
                        if (b == 8'd0 && length_shift != 7'd0)
                            err = ST_BAD_VARINT;
                        else
                            fin = enter_phase(phase_t'(cur_phase + 1), length_acc);
                    end else begin
                        length_shift = length_shift + 7'd7;
                    end
                end
            end else if (cur_phase >= PH_NSD && cur_phase < PH_FIN) begin
                data = 1'b1;
                tag  = tag_for(cur_phase);
                pay  = (cur_phase == PH_PRS) ? {7'd0, b != 8'd0} : b;
                if (field_left != 64'd0)
                    field_left = field_left - 64'd1;
                if (field_left == 64'd0) begin
                    nx   = after_phase(cur_phase);
                    fend = 1'b1;
                    fin  = enter_phase(nx, fixed_length(nx));
                end
            end else begin
                cur_phase = PH_VER;
                err       = ST_TRUNCATED;
            end
        end

        // A content error on the last byte takes precedence over truncation.
        if (err == ST_OK && !fin && last)
            err = ST_TRUNCATED;

        if (err != ST_OK || fin) begin
            cur_phase = PH_VER;
            if (err != ST_OK && !last)
                draining = 1'b1;
        end

        if (!data && err == ST_OK && !fin)
            return 1'b0;

        r.field_tag      = tag;
        r.data_valid     = data;
        r.payload_byte   = pay;
        r.field_end      = fend;
        r.record_kind    = kind_is_register;
        r.record_done    = (err != ST_OK) || fin;
        r.status         = err;
        r.consumed_bytes = ((err != ST_OK) || fin) ? record_count : 32'd0;
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            regs.expected_version    = RST_EXPECTED_VERSION;
            regs.existence_kind_code = RST_EXISTENCE_KIND;
            regs.register_kind_code  = RST_REGISTER_KIND;
            regs.author_key_length   = RST_AUTHOR_KEY_LEN;
            regs.signature_length    = RST_SIGNATURE_LEN;
            cur_phase        = PH_VER;
            kind_is_register = 1'b0;
            length_acc       = 64'd0;
            length_shift     = 7'd0;
            field_left       = 64'd0;
            record_count     = 32'd0;
            draining         = 1'b0;
            expected_results.delete();
        end else begin
            // Compare each delivered result item with the oldest expectation.
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result item with nothing expected, tag", m_field_tag, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_field_tag !== want.field_tag)
                        report_mismatch("field_tag", m_field_tag, want.field_tag);
                    if (m_data_valid !== want.data_valid)
                        report_mismatch("data_valid", m_data_valid, want.data_valid);
                    if (m_payload_byte !== want.payload_byte)
                        report_mismatch("payload_byte", m_payload_byte, want.payload_byte);
                    if (m_field_end !== want.field_end)
                        report_mismatch("field_end", m_field_end, want.field_end);
                    if (m_record_kind !== want.record_kind)
                        report_mismatch("record_kind", m_record_kind, want.record_kind);
                    if (m_record_done !== want.record_done)
                        report_mismatch("record_done", m_record_done, want.record_done);
                    if (m_status !== want.status)
                        report_mismatch("status", m_status, want.status);
                    if (m_consumed_bytes !== want.consumed_bytes)
                        report_mismatch("consumed_bytes", m_consumed_bytes, want.consumed_bytes);
                end
            end

            // Register writes update the local copy.
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_EXPECTED_VERSION: regs.expected_version    = cfg_data;
                    CFG_EXISTENCE_KIND:   regs.existence_kind_code = cfg_data;
                    CFG_REGISTER_KIND:    regs.register_kind_code  = cfg_data;
                    CFG_AUTHOR_KEY_LEN:   regs.author_key_length   = cfg_data;
                    CFG_SIGNATURE_LEN:    regs.signature_length    = cfg_data;
                    default: ;
                endcase
            end

            // Each accepted byte gives at most one expected result item.
            if (s_valid && s_ready) begin
                if (decode_record_byte(s_in_byte, s_buffer_end, want))
                    expected_results.insert(expected_results.size(), want);
            end
        end
        pending_q <= expected_results.size();
    end

endmodule

// ----- test/tb.sv -----
// Top of the canonical record parser testbench: clock, reset, register writes,
// record stimulus, result back-pressure and the verdict.
// Depends on crp_pkg, canonical_record_parser and crp_stream_checker.
`timescale 1ns / 100ps

module tb;
    import crp_pkg::*;

    localparam int         WATCHDOG_LIMIT   = 5000;
    localparam int         SETTLE_CYCLES    = 16;
    localparam logic [2:0] CFG_UNUSED_INDEX = 3'd7;

    typedef enum {
        REC_GOOD,
        REC_CUT,
        REC_HUGE_LEN,
        REC_BAD_VERSION,
        REC_BAD_KIND,
        REC_BAD_VARINT,
        REC_NOISE
    } rec_mode_t;

    typedef enum {
        VF_PADDING,
        VF_TOP_BITS,
        VF_OVERFLOW
    } varint_fault_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 3'd0;
    logic [7:0]  cfg_data = 8'd0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = 8'd0;
    logic        s_buffer_end = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_field_tag;
    logic        m_data_valid;
    logic [7:0]  m_payload_byte;
    logic        m_field_end;
    logic        m_record_kind;
    logic        m_record_done;
    logic [2:0]  m_status;
    logic [31:0] m_consumed_bytes;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int sink_hold = 0;
    int items_sent = 0;
    bit sender_eager = 1'b0;

    // Register values currently in the block, used to shape the records.
    cfg_t       cur;
    logic [8:0] record_bytes[$];

    always #5 aclk = ~aclk;

    canonical_record_parser DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_in_byte        (s_in_byte),
        .s_buffer_end     (s_buffer_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_field_tag      (m_field_tag),
        .m_data_valid     (m_data_valid),
        .m_payload_byte   (m_payload_byte),
        .m_field_end      (m_field_end),
        .m_record_kind    (m_record_kind),
        .m_record_done    (m_record_done),
        .m_status         (m_status),
        .m_consumed_bytes (m_consumed_bytes)
    );

    crp_stream_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_in_byte        (s_in_byte),
        .s_buffer_end     (s_buffer_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_field_tag      (m_field_tag),
        .m_data_valid     (m_data_valid),
        .m_payload_byte   (m_payload_byte),
        .m_field_end      (m_field_end),
        .m_record_kind    (m_record_kind),
        .m_record_done    (m_record_done),
        .m_status         (m_status),
        .m_consumed_bytes (m_consumed_bytes),
        .mismatch_total   (fail_count),
        .results_pending  (pending)
    );

    // Idle lengths: mostly none, some short, a few long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // Receiver alternates ready stretches, some of them long, with stalls.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            sink_hold <= 0;
        end else if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
        end else if (m_ready) begin
            m_ready   <= 1'b0;
            sink_hold <= gap_len();
        end else begin
            m_ready   <= 1'b1;
            sink_hold <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(0, 30);
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] value, input logic last);
        int gap;
        gap = sender_eager ? 0 : gap_len();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_in_byte    <= value;
        s_buffer_end <= last;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Only called while the block is idle at a record boundary.
    task automatic apply_settings(input logic [7:0] version, input logic [7:0] ex_kind,
                                  input logic [7:0] reg_kind, input logic [7:0] auth_len,
                                  input logic [7:0] sig_len, input logic poke_unused);
        write_register(CFG_EXPECTED_VERSION, version);
        write_register(CFG_EXISTENCE_KIND, ex_kind);
        write_register(CFG_REGISTER_KIND, reg_kind);
        write_register(CFG_AUTHOR_KEY_LEN, auth_len);
        write_register(CFG_SIGNATURE_LEN, sig_len);
        if (poke_unused)
            write_register(CFG_UNUSED_INDEX, 8'($urandom_range(0, 255)));
        cfg_valid <= 1'b0;
        cur.expected_version    = version;
        cur.existence_kind_code = ex_kind;
        cur.register_kind_code  = reg_kind;
        cur.author_key_length   = auth_len;
        cur.signature_length    = sig_len;
    endtask

    // Stop sending, wait for every expected result item, then let the block drain.
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic push_byte(input logic [7:0] value);
        record_bytes.insert(record_bytes.size(), {1'b0, value});
    endtask

    task automatic push_random(input int count);
        repeat (count) push_byte(8'($urandom_range(0, 255)));
    endtask

    // Minimal LEB128 encoding of a length.
    task automatic push_varint(input logic [63:0] value);
        logic [63:0] rest;
        rest = value;
        do begin
            push_byte({rest > 64'd127, rest[6:0]});
            rest = rest >> 7;
        end while (rest != 64'd0);
    endtask

    task automatic push_bad_varint(input varint_fault_t fault);
        int groups;
        groups = (fault == VF_PADDING) ? $urandom_range(1, 9) : 9;
        repeat (groups) push_byte(VARINT_CONT_MASK | 8'($urandom_range(0, 127)));
        case (fault)
            VF_PADDING:  push_byte(8'h00);
            VF_TOP_BITS: push_byte(8'($urandom_range(0, 255)) | (8'h01 << $urandom_range(1, 6)));
            default: begin
                // The tenth group continues, so the next byte overflows.
                push_byte(VARINT_CONT_MASK | 8'($urandom_range(0, 1)));
                push_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // Random bytes, the last one marking the buffer end so the parser resyncs.
    task automatic push_noise();
        repeat ($urandom_range(0, 3))
            record_bytes.insert(record_bytes.size(),
                                {($urandom_range(0, 3) == 0), 8'($urandom_range(0, 255))});
        record_bytes.insert(record_bytes.size(), {1'b1, 8'($urandom_range(0, 255))});
    endtask

    // Mostly short fields, now and then one that needs a two-group length.
    function automatic int field_length();
        return ($urandom_range(0, 15) == 0) ? $urandom_range(128, 135) : $urandom_range(0, 5);
    endfunction

    task automatic build_record(input rec_mode_t mode);
        logic [7:0] b;
        logic       is_reg;
        logic       stop;
        int         slots;
        int         bad_slot;
        int         cut;
        record_bytes.delete();
        if (mode == REC_NOISE) begin
            push_noise();
            return;
        end
        is_reg = $urandom_range(0, 1);
        if (cur.existence_kind_code == cur.register_kind_code)
            is_reg = 1'b0;
        slots    = is_reg ? 4 : 2;
        bad_slot = (mode == REC_BAD_VARINT || mode == REC_HUGE_LEN) ? $urandom_range(1, slots) : 0;
        stop     = 1'b0;

        // Version and kind bytes.
        if (mode == REC_BAD_VERSION) begin
            do b = 8'($urandom_range(0, 255)); while (b == cur.expected_version);
            push_byte(b);
            stop = 1'b1;
        end else begin
            push_byte(cur.expected_version);
            if (mode == REC_BAD_KIND) begin
                do b = 8'($urandom_range(0, 255));
                while (b == cur.existence_kind_code || b == cur.register_kind_code);
                push_byte(b);
                stop = 1'b1;
            end else begin
                push_byte(is_reg ? cur.register_kind_code : cur.existence_kind_code);
            end
        end

        // Length-prefixed fields; a faulty or huge length ends the sequence.
        for (int slot = 1; slot <= slots && !stop; slot++) begin
            if (slot == bad_slot) begin
                if (mode == REC_HUGE_LEN) begin
                    repeat (9) push_byte(VARINT_CONT_MASK | 8'($urandom_range(0, 127)));
                    push_byte(8'h01);
                    push_random($urandom_range(1, 4));
                end else begin
                    push_bad_varint(varint_fault_t'($urandom_range(0, 2)));
                end
                stop = 1'b1;
            end else begin
                cut = field_length();
                push_varint(64'(cut));
                push_random(cut);
            end
        end

        // Present byte for existence records, then the clocks, the key and the signature.
        if (!stop) begin
            if (!is_reg)
                push_byte(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
            push_random(int'(LEN_PHYSICAL));
            push_random(int'(LEN_LOGICAL));
            push_random(cur.author_key_length);
            push_random(cur.signature_length);
        end

        case (mode)
            REC_GOOD: begin
                if ($urandom_range(0, 1) == 0)
                    record_bytes[record_bytes.size() - 1][8] = 1'b1;
            end
            REC_CUT: begin
                cut = $urandom_range(0, record_bytes.size() - 1);
                while (record_bytes.size() > cut + 1)
                    void'(record_bytes.pop_back());
                record_bytes[record_bytes.size() - 1][8] = 1'b1;
            end
            REC_HUGE_LEN: record_bytes[record_bytes.size() - 1][8] = 1'b1;
            default: begin
                // Error byte either carries the buffer end itself or is followed by a drain.
                if ($urandom_range(0, 1) == 0)
                    record_bytes[record_bytes.size() - 1][8] = 1'b1;
                else
                    push_noise();
            end
        endcase
    endtask

    task automatic run_random(input int budget);
        int start;
        int pick;
        start = items_sent;
        while (items_sent - start < budget) begin
            pick = $urandom_range(0, 99);
            sender_eager = ($urandom_range(0, 3) == 0);
            if (pick < 55)
                build_record(REC_GOOD);
            else if (pick < 67)
                build_record(REC_CUT);
            else if (pick < 72)
                build_record(REC_HUGE_LEN);
            else if (pick < 78)
                build_record(REC_BAD_VERSION);
            else if (pick < 84)
                build_record(REC_BAD_KIND);
            else if (pick < 94)
                build_record(REC_BAD_VARINT);
            else
                build_record(REC_NOISE);
            foreach (record_bytes[i])
                send_item(record_bytes[i][7:0], record_bytes[i][8]);
            // Now and then hold off until every result item has come back.
            if ($urandom_range(0, 39) == 0) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (pending != 0);
            end
        end
    endtask

    initial begin
        cur.expected_version    = RST_EXPECTED_VERSION;
        cur.existence_kind_code = RST_EXISTENCE_KIND;
        cur.register_kind_code  = RST_REGISTER_KIND;
        cur.author_key_length   = RST_AUTHOR_KEY_LEN;
        cur.signature_length    = RST_SIGNATURE_LEN;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset values: long author key and signature.
        run_random(300);
        settle();

        // Shortest key and signature; the directed cases run here.
        apply_settings(8'h00, 8'hff, 8'h00, 8'd1, 8'd1, 1'b0);
        // Version byte with buffer end is truncated even though it is wrong.
        send_item(8'hff, 1'b1);
        // A wrong version drains the following bytes up to the buffer end.
        send_item(8'h7f, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b1);
        // Bad kind on the buffer-end byte reports the kind error.
        send_item(8'h00, 1'b0);
        send_item(8'h5a, 1'b1);
        // Zero padding group in the namespace length.
        send_item(8'h00, 1'b0);
        send_item(8'hff, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h00, 1'b1);
        // Register record truncated on its first namespace byte.
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(8'hff, 1'b1);
        // Existence record with empty names, present byte normalized, truncated there.
        send_item(8'h00, 1'b0);
        send_item(8'hff, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h80, 1'b1);
        run_random(250);
        settle();

        // Equal kind codes: every record is an existence record.
        apply_settings(8'hff, 8'h5a, 8'h5a, 8'd3, 8'd2, 1'b0);
        run_random(200);
        settle();

        // Longest key and signature.
        apply_settings(8'h80, 8'h00, 8'hff, 8'd255, 8'd255, 1'b0);
        run_random(450);
        settle();

        // Zero-length key and signature, plus a write to an unused index.
        apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'd0, 8'd0, 1'b1);
        run_random(150);
        settle();

        apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(1, 8)),
                       8'($urandom_range(1, 8)), 1'b0);
        run_random(300);
        settle();

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
